/* sv/assert_macros.svh */
// assertion macros shared by the sha-256 compressor modules
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed: property does not hold");

`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed: forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)

`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

/* sv/shc_pkg.sv */
// shared types, constants and round functions of the sha-256 compressor
// no dependencies; imported by every module of the block
`default_nettype none

package shc_pkg;

   localparam int WORD_W = 32;
   localparam logic [3:0] LAST_POS = 4'd15;

   typedef logic [WORD_W-1:0] word_type;

   // element 0 is working variable a / hash word h0
   typedef logic [7:0][WORD_W-1:0] hash_array_type;

   // one classified message word on its way to the round engine
   typedef struct packed {
      word_type word;
      logic     start;
      logic     digest;
   } queue_entry_type;

   localparam hash_array_type HASH_INIT = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type big_sigma0(word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sigma1(word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type small_sigma0(word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
   endfunction

   // one compression round
   function automatic hash_array_type sha_round(hash_array_type v, word_type k,
                                                word_type w);
      word_type       t1;
      word_type       t2;
      hash_array_type r;
      t1 = v[7] + big_sigma1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k + w;
      t2 = big_sigma0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      r[7] = v[6];
      r[6] = v[5];
      r[5] = v[4];
      r[4] = v[3] + t1;
      r[3] = v[2];
      r[2] = v[1];
      r[1] = v[0];
      r[0] = t1 + t2;
      return r;
   endfunction

endpackage

`default_nettype wire

/* sv/sha256_block_compressor.sv */
// SHA-256 block compressor. Message words enter one per handshake and are
// queued; the round engine runs one compression round per clock unless it
// waits on an empty queue, taking each of the first sixteen schedule words
// straight from the queue; a fold state then adds the working variables
// into the hash, and a block that ends a message is followed by its eight
// digest words, held while the result side stalls. The word queue lets the
// input side keep taking words while rounds run or digest words wait.
// Depends on shc_pkg, shc_front, shc_word_queue, shc_back.
`default_nettype none

module sha256_block_compressor #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [31:0] req_message_word,
   input  wire         req_start_message,
   input  wire         req_end_message,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic        rsp_last_word
);
   import shc_pkg::*;

   logic            push;
   queue_entry_type push_entry;
   logic            queue_full;
   logic            pop;
   logic            head_valid;
   queue_entry_type head_entry;

   shc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_message_word (req_message_word),
      .req_start_message(req_start_message),
      .req_end_message  (req_end_message),
      .queue_full       (queue_full),
      .push             (push),
      .push_entry       (push_entry)
   );

   shc_word_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   shc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_entry      (head_entry),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_last_word   (rsp_last_word)
   );

endmodule

`default_nettype wire

/* sv/shc_front.sv */
// input side: tracks the word position in the block and tags each word
// depends on shc_pkg
`default_nettype none

module shc_front (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  wire  [31:0]             req_message_word,
   input  wire                     req_start_message,
   input  wire                     req_end_message,
   input  wire                     queue_full,
   output logic                    push,
   output shc_pkg::queue_entry_type push_entry
);
   import shc_pkg::*;

   logic [3:0] count_ff;
   logic [3:0] count_in;
   logic [3:0] pos;

   always_comb begin
      // a start word always opens a fresh block
      pos = req_start_message ? 4'd0 : count_ff;
      req_stall = queue_full;
      push = req_valid && !queue_full;
      push_entry.word = req_message_word;
      push_entry.start = req_start_message;
      push_entry.digest = req_end_message && (pos == LAST_POS);
      count_in = push ? pos + 4'd1 : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

/* sv/shc_word_queue.sv */
// short word queue between the input side and the round engine
// depends on shc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module shc_word_queue #(
   parameter int DEPTH = 4
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      push,
   input  shc_pkg::queue_entry_type push_entry,
   output logic                     full,
   input  wire                      pop,
   output logic                     head_valid,
   output shc_pkg::queue_entry_type head_entry
);
   import shc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   queue_entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_in;

   always_comb begin
      full = (count_ff == CNT_W'(DEPTH));
      head_valid = (count_ff != '0);
      head_entry = mem_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   `ASSERT_NEVER(a_queue_overfill, clock, reset, count_ff > CNT_W'(DEPTH))
   `ASSERT_PROP(a_pop_not_empty, clock, reset, pop |-> count_ff != '0)
   `ASSERT_PROP(a_push_not_full, clock, reset, push |-> !full)

endmodule

`default_nettype wire

/* sv/shc_back.sv */
// round engine: schedule window, one round per cycle unless the queue is
// empty, hash fold, digest output; depends on shc_pkg, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module shc_back (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      head_valid,
   input  shc_pkg::queue_entry_type head_entry,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output logic [31:0]              rsp_digest_word,
   output logic                     rsp_last_word
);
   import shc_pkg::*;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_FOLD,
      ST_OUT
   } state_type;

   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [3:0] LAST_SCHED = 4'd15;
   localparam logic [2:0] LAST_DIGEST = 3'd7;

   state_type               state_ff;
   logic [5:0]              round_ff;
   logic [2:0]              idx_ff;
   logic                    digest_ff;
   hash_array_type          hash_ff;
   hash_array_type          vars_ff;
   logic [15:0][WORD_W-1:0] sched_ff;

   logic                    from_queue;
   logic                    restart;
   logic                    advance;
   word_type                sched_next;
   word_type                w_now;
   hash_array_type          cur_vars;
   hash_array_type          round_out;
   hash_array_type          fold_sum;

   always_comb begin
      from_queue = (round_ff[5:4] == 2'd0);
      pop = head_valid && (state_ff == ST_RUN) && from_queue;
      restart = pop && head_entry.start;
      advance = (state_ff == ST_RUN) && (!from_queue || pop);
      // sched_ff[0] holds w[t-16], sched_ff[15] holds w[t-1]
      sched_next = sched_ff[0] + small_sigma0(sched_ff[1]) + sched_ff[9]
                 + small_sigma1(sched_ff[14]);
      w_now = from_queue ? head_entry.word : sched_next;
      cur_vars = restart ? HASH_INIT : vars_ff;
      // a start word is always round zero of its block
      round_out = sha_round(cur_vars, ROUND_K[restart ? 6'd0 : round_ff], w_now);
      for (int i = 0; i < 8; i++) begin
         fold_sum[i] = hash_ff[i] + vars_ff[i];
      end
      rsp_valid = (state_ff == ST_OUT);
      rsp_digest_word = hash_ff[idx_ff];
      rsp_last_word = (idx_ff == LAST_DIGEST);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         round_ff <= '0;
         idx_ff <= '0;
         digest_ff <= 1'b0;
         hash_ff <= HASH_INIT;
         vars_ff <= HASH_INIT;
      end else begin
         unique case (state_ff)
            ST_RUN: begin
               if (advance) begin
                  vars_ff <= round_out;
                  sched_ff <= {w_now, sched_ff[15:1]};
                  if (restart) begin
                     // a start word drops any partial block and reloads
                     hash_ff <= HASH_INIT;
                     round_ff <= 6'd1;
                  end else begin
                     round_ff <= round_ff + 6'd1;
                  end
                  if (pop && round_ff[3:0] == LAST_SCHED) begin
                     digest_ff <= head_entry.digest;
                  end
                  if (round_ff == LAST_ROUND) begin
                     state_ff <= ST_FOLD;
                  end
               end
            end
            ST_FOLD: begin
               hash_ff <= fold_sum;
               vars_ff <= fold_sum;
               idx_ff <= '0;
               state_ff <= digest_ff ? ST_OUT : ST_RUN;
            end
            ST_OUT: begin
               if (!rsp_stall) begin
                  idx_ff <= idx_ff + 3'd1;
                  if (idx_ff == LAST_DIGEST) begin
                     state_ff <= ST_RUN;
                  end
               end
            end
            default: begin
               state_ff <= ST_RUN;
            end
         endcase
      end
   end

   `ASSERT_PROP(a_last_round_folds, clock, reset,
      (state_ff == ST_RUN && round_ff == LAST_ROUND) |=> state_ff == ST_FOLD)
   `ASSERT_PROP(a_digest_follows_fold, clock, reset,
      (state_ff == ST_FOLD && digest_ff) |=> rsp_valid)
   `ASSERT_PROP(a_last_word_ends_out, clock, reset,
      (rsp_valid && !rsp_stall && rsp_last_word) |=> (!rsp_valid && round_ff == 6'd0))

endmodule

`default_nettype wire
